// ===== rtl/szbe_pkg.sv =====
// Shared constants, record types and queue entry layout for the sparse zero-block encoder.
package szbe_pkg;

   // Fixed geometry of one input block and of the offsets
   localparam int BLOCK_BYTES     = 8;
   localparam int OFF_W           = 32;
   localparam int VB_W            = 4;
   localparam int TAIL_W          = 3;
   localparam int DATA_W          = BLOCK_BYTES * 8;

   // Gap counter and its default limit
   localparam int ZBC_W           = 10;
   localparam int GAP_BLOCKS_DEF  = 512;

   // Records one item can cause, and the queue between front and back
   localparam int REC_SLOTS       = 3;
   localparam int SLOT_W          = 2;
   localparam int CAND_NUM        = 4;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Stream widths
   localparam int REQ_TDATA_W     = 72;
   localparam int RSP_TDATA_W     = 64;

   // One record as operand pairs: skip = skip_a - skip_b, len = len_a - len_b
   typedef struct packed {
      logic [OFF_W-1:0] skip_a;
      logic [OFF_W-1:0] skip_b;
      logic [OFF_W-1:0] len_a;
      logic [OFF_W-1:0] len_b;
      logic             end_marker;
   } rec_type;

   // All records caused by one accepted block
   typedef struct packed {
      rec_type [REC_SLOTS-1:0] recs;
      logic    [SLOT_W-1:0]    count;
      logic                    overflow;
   } bundle_type;

   // Head-of-queue view handed to the back end
   typedef struct packed {
      logic       valid;
      bundle_type head;
   } queue_head_type;

endpackage

// ===== rtl/szbe_front.sv =====
// Front end: accepts blocks, tracks runs and gaps, and builds the record bundle for each block.
module szbe_front
   import szbe_pkg::*;
#(
   parameter int GAP_BLOCKS = GAP_BLOCKS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_wdata,
   input  logic                in_valid,
   input  logic [DATA_W-1:0]   in_data,
   input  logic [VB_W-1:0]     in_vb,
   input  logic                in_last,
   input  logic                q_full,
   output logic                in_ready,
   output logic                push,
   output bundle_type          push_bundle
);

   localparam logic [ZBC_W-1:0] GAP_LIMIT = ZBC_W'(GAP_BLOCKS);

   // Region state
   logic               delta_ff,  delta_in;
   logic [OFF_W-1:0]   off_ff,    off_in;
   logic               open_ff,   open_in;
   logic [OFF_W-1:0]   start_ff,  start_in;
   logic [OFF_W-1:0]   lde_ff,    lde_in;
   logic [OFF_W-1:0]   lde8_ff,   lde8_in;
   logic [OFF_W-1:0]   pre_ff,    pre_in;
   logic [ZBC_W-1:0]   zbc_ff,    zbc_in;
   logic               ovf_ff,    ovf_in;

   // Per-block classification
   logic               accept;
   logic               full_blk;
   logic               nz;
   logic [TAIL_W-1:0]  tail_len;
   logic [TAIL_W:0]    tail_top;
   logic               tail_nz;
   logic [OFF_W:0]     blk_sum;
   logic [OFF_W-1:0]   blk_end;
   logic [OFF_W-1:0]   off_p16;
   logic               gap_close;

   // State after the full-block step, before the final-block handling
   logic [OFF_W-1:0]   off1;
   logic               open1;
   logic [OFF_W-1:0]   start1;
   logic [OFF_W-1:0]   lde1;
   logic [OFF_W-1:0]   lde8_1;
   logic [OFF_W-1:0]   pre1;
   logic [ZBC_W-1:0]   zbc1;
   logic               ovf1;
   logic [OFF_W-1:0]   rec_end;

   rec_type [CAND_NUM-1:0] cand;
   logic    [CAND_NUM-1:0] cand_v;
   logic    [SLOT_W-1:0]   n_rec;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   // Classify the block
   assign full_blk = !in_last || (in_vb >= VB_W'(BLOCK_BYTES));
   assign nz       = |in_data;
   assign tail_len = (in_last && !full_blk) ? in_vb[TAIL_W-1:0] : '0;
   assign blk_sum  = {1'b0, off_ff} + (OFF_W+1)'(BLOCK_BYTES);
   assign blk_end  = blk_sum[OFF_W-1:0];
   assign off_p16  = off_ff + OFF_W'(2 * BLOCK_BYTES);
   assign gap_close = full_blk && !nz && open_ff && (zbc_ff >= GAP_LIMIT);

   // Find one past the highest nonzero valid tail byte
   always_comb begin
      tail_top = '0;
      for (int k = 0; k < BLOCK_BYTES; k++) begin
         if ((k < int'(tail_len)) && (in_data[k*8 +: 8] != 8'd0)) begin
            tail_top = (TAIL_W+1)'(k + 1);
         end
      end
   end
   assign tail_nz = (tail_top != '0);

   // Advance run tracking over a full block
   always_comb begin
      off1   = full_blk ? blk_end : off_ff;
      start1 = (full_blk && nz && !open_ff) ? off_ff : start_ff;
      lde1   = (full_blk && nz) ? blk_end : lde_ff;
      lde8_1 = (full_blk && nz) ? off_p16 : lde8_ff;
      pre1   = gap_close ? lde8_ff : pre_ff;
      ovf1   = ovf_ff | (full_blk & blk_sum[OFF_W]);
      open1  = open_ff;
      zbc1   = zbc_ff;
      if (full_blk) begin
         if (nz) begin
            open1 = 1'b1;
            zbc1  = '0;
         end else if (gap_close) begin
            open1 = 1'b0;
            zbc1  = '0;
         end else if (open_ff) begin
            zbc1  = zbc_ff + ZBC_W'(1);
         end
      end
      rec_end = (zbc1 != '0) ? lde8_1 : lde1;
   end

   // Build candidate records in emission order
   always_comb begin
      cand   = '0;
      cand_v = '0;

      // Gap closure inside the region
      cand[0].skip_a = start_ff;
      cand[0].skip_b = pre_ff;
      cand[0].len_a  = lde8_ff;
      cand[0].len_b  = start_ff;
      cand_v[0]      = gap_close && !delta_ff;

      // Open run closed at the end of the region
      cand[1].skip_a = start1;
      cand[1].skip_b = pre1;
      cand[1].len_a  = rec_end;
      cand[1].len_b  = start1;
      cand_v[1]      = in_last && !delta_ff && open1;

      // Tail record, or the single delta record
      if (delta_ff) begin
         cand[2].len_a = tail_nz ? off1 : lde1;
         cand[2].len_b = tail_nz ? (OFF_W'(0) - OFF_W'(tail_top)) : '0;
         cand_v[2]     = in_last && (tail_nz || (lde1 != '0));
      end else begin
         cand[2].skip_a = off1;
         cand[2].skip_b = open1 ? rec_end : pre1;
         cand[2].len_a  = OFF_W'(tail_len);
         cand_v[2]      = in_last && tail_nz;
      end

      // Terminator
      cand[3].end_marker = 1'b1;
      cand_v[3]          = in_last;
   end

   // Pack the valid candidates into the bundle
   always_comb begin
      push_bundle = '0;
      n_rec       = '0;
      for (int k = 0; k < CAND_NUM; k++) begin
         if (cand_v[k] && (n_rec < SLOT_W'(REC_SLOTS))) begin
            push_bundle.recs[n_rec] = cand[k];
            n_rec = n_rec + SLOT_W'(1);
         end
      end
      push_bundle.count    = n_rec;
      push_bundle.overflow = ovf1;
   end

   assign push = accept && (n_rec != '0);

   // Next region state: clear after the final block
   always_comb begin
      delta_in = csr_we ? csr_wdata : delta_ff;
      off_in   = off_ff;
      open_in  = open_ff;
      start_in = start_ff;
      lde_in   = lde_ff;
      lde8_in  = lde8_ff;
      pre_in   = pre_ff;
      zbc_in   = zbc_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (in_last) begin
            off_in   = '0;
            open_in  = 1'b0;
            start_in = '0;
            lde_in   = '0;
            lde8_in  = OFF_W'(BLOCK_BYTES);
            pre_in   = '0;
            zbc_in   = '0;
            ovf_in   = 1'b0;
         end else begin
            off_in   = off1;
            open_in  = open1;
            start_in = start1;
            lde_in   = lde1;
            lde8_in  = lde8_1;
            pre_in   = pre1;
            zbc_in   = zbc1;
            ovf_in   = ovf1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= 1'b0;
         off_ff   <= '0;
         open_ff  <= 1'b0;
         start_ff <= '0;
         lde_ff   <= '0;
         lde8_ff  <= OFF_W'(BLOCK_BYTES);
         pre_ff   <= '0;
         zbc_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         delta_ff <= delta_in;
         off_ff   <= off_in;
         open_ff  <= open_in;
         start_ff <= start_in;
         lde_ff   <= lde_in;
         lde8_ff  <= lde8_in;
         pre_ff   <= pre_in;
         zbc_ff   <= zbc_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== rtl/szbe_queue.sv =====
// Short queue of record bundles between the front and back ends.
module szbe_queue
   import szbe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  bundle_type     push_bundle,
   input  logic           pop,
   output logic           full,
   output queue_head_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type        mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     cnt_ff,    cnt_in;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.head  = mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

// ===== rtl/szbe_back.sv =====
// Back end: walks the records of the head bundle and drives the result register.
module szbe_back
   import szbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_head_type   head,
   output logic             pop,
   input  logic             out_ready,
   output logic             out_valid,
   output logic [OFF_W-1:0] out_skip,
   output logic [OFF_W-1:0] out_len,
   output logic             out_end,
   output logic             out_ovf
);

   logic             valid_ff, valid_in;
   logic [SLOT_W-1:0] idx_ff,  idx_in;
   logic [OFF_W-1:0] skip_ff, skip_in;
   logic [OFF_W-1:0] len_ff,  len_in;
   logic             end_ff,  end_in;
   logic             ovf_ff,  ovf_in;

   logic             can_load;
   logic             load;
   logic             last_rec;
   rec_type          cur;

   assign can_load = !valid_ff || out_ready;
   assign load     = can_load && head.valid;
   assign cur      = head.head.recs[idx_ff];
   assign last_rec = (idx_ff == (head.head.count - SLOT_W'(1)));
   assign pop      = load && last_rec;

   // Load the next record, finishing its subtractions
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      skip_in  = skip_ff;
      len_in   = len_ff;
      end_in   = end_ff;
      ovf_in   = ovf_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_rec ? '0 : idx_ff + SLOT_W'(1);
         skip_in  = cur.skip_a - cur.skip_b;
         len_in   = cur.len_a - cur.len_b;
         end_in   = cur.end_marker;
         ovf_in   = head.head.overflow;
      end else if (can_load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      skip_ff <= skip_in;
      len_ff  <= len_in;
      end_ff  <= end_in;
      ovf_ff  <= ovf_in;
   end

   assign out_valid = valid_ff;
   assign out_skip  = skip_ff;
   assign out_len   = len_ff;
   assign out_end   = end_ff;
   assign out_ovf   = ovf_ff;

endmodule

// ===== rtl/sparse_zero_block_encoder_top.sv =====
// Top level of the sparse zero-block encoder: front end, bundle queue and back end.
//
//   channel   direction  transfer unit           tdata / tuser / tlast
//   req_      in         one 8-byte block        block_data, valid_bytes / - / last_block
//   rsp_      out        one (skip, len) record  skip, len / overflow / end_marker
//   csr_      in         delta_layout write      csr_wdata, taken when csr_we is high
//
// A block is taken every cycle while the queue has room; its records are written into the
// queue as one bundle in the same cycle as the transfer. The back end sends one record per
// cycle while rsp_ does not stall, so a block with three records holds the back end until
// all three are sent. Reset is synchronous: it clears the region state, sets delta_layout
// to 0 and empties the queue. A stall on rsp_ stops the back end only; req_ keeps taking
// blocks until QUEUE_DEPTH bundles wait.
module sparse_zero_block_encoder_top
   import szbe_pkg::*;
#(
   parameter int GAP_BLOCKS  = GAP_BLOCKS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // block_data[63:0], valid_bytes[67:64], zero pad
   input  logic                   req_tlast,  // last_block
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // skip[31:0], len[63:32]
   output logic                   rsp_tuser,  // overflow
   output logic                   rsp_tlast   // end_marker
);

   logic             q_full;
   logic             push;
   bundle_type       push_bundle;
   logic             pop;
   queue_head_type   q_head;
   logic [OFF_W-1:0] rsp_skip;
   logic [OFF_W-1:0] rsp_len;

   szbe_front #(
      .GAP_BLOCKS (GAP_BLOCKS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .in_valid    (req_tvalid),
      .in_data     (req_tdata[DATA_W-1:0]),
      .in_vb       (req_tdata[DATA_W +: VB_W]),
      .in_last     (req_tlast),
      .q_full      (q_full),
      .in_ready    (req_tready),
      .push        (push),
      .push_bundle (push_bundle)
   );

   szbe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (q_full),
      .head        (q_head)
   );

   szbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .pop       (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_skip  (rsp_skip),
      .out_len   (rsp_len),
      .out_end   (rsp_tlast),
      .out_ovf   (rsp_tuser)
   );

   assign rsp_tdata = {rsp_len, rsp_skip};

endmodule

// ===== sim/sparse_zero_block_encoder_top_tb.sv =====
// Self-checking testbench for the sparse zero-block encoder: directed and random block streams, record check.
module sparse_zero_block_encoder_top_tb;
   import szbe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // delta_layout register values
   localparam bit LAYOUT_MINIMIZED = 1'b0;
   localparam bit LAYOUT_DELTA     = 1'b1;

   localparam int GAP_LIMIT    = GAP_BLOCKS_DEF;
   localparam int DRAIN_CYCLES = 16;
   localparam int PAD_W        = REQ_TDATA_W - DATA_W - VB_W;
   localparam int RANDOM_ITEMS = 220;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [VB_W-1:0]   valid_bytes;
      logic              last;
   } block_item_type;

   typedef struct packed {
      logic [OFF_W-1:0] skip;
      logic [OFF_W-1:0] len;
      logic             end_marker;
      logic             overflow;
   } enc_record_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic                   csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   block_item_type pending_blocks[$];
   enc_record_type expected_records[$];
   int             mismatch_count = 0;
   int             region_left = 0;

   // Encoder image: configuration and region state
   bit          layout_mode = LAYOUT_MINIMIZED;
   logic [31:0] scan_offset;
   bit          run_active;
   logic [31:0] run_base;
   logic [31:0] data_end;
   logic [31:0] record_end;
   int unsigned zero_run;
   bit          span_overflow;

   // Handshake pacing
   int req_gap, req_calm, rsp_hold, rsp_calm;

   sparse_zero_block_encoder_top #(
      .GAP_BLOCKS (GAP_LIMIT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Generous limit on the whole run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic clear_region();
      scan_offset   = '0;
      run_active    = 1'b0;
      run_base      = '0;
      data_end      = '0;
      record_end    = '0;
      zero_run      = 0;
      span_overflow = 1'b0;
   endtask

   task automatic expect_record(input logic [31:0] skip, input logic [31:0] len,
                                input logic end_marker);
      enc_record_type rec;
      rec.skip       = skip;
      rec.len        = len;
      rec.end_marker = end_marker;
      rec.overflow   = span_overflow;
      expected_records.push_back(rec);
   endtask

   // Advance the region state by one block and queue the records it closes
   task automatic encode_block(input logic [63:0] data, input logic [3:0] vb,
                               input logic last);
      logic [31:0] blk_end;
      logic [31:0] rec_end;
      logic [31:0] reach;
      logic [63:0] tail;
      int unsigned nbytes;
      int unsigned tail_len;
      int unsigned i;
      nbytes = !last ? BLOCK_BYTES : (vb > BLOCK_BYTES ? BLOCK_BYTES : vb);
      if (nbytes == BLOCK_BYTES) begin
         blk_end = scan_offset + 32'(BLOCK_BYTES);
         if (blk_end < scan_offset)
            span_overflow = 1'b1;
         if (data != '0) begin
            if (!run_active) begin
               run_active = 1'b1;
               run_base   = scan_offset;
            end
            data_end = blk_end;
            zero_run = 0;
         end else if (run_active) begin
            if (zero_run >= GAP_LIMIT) begin
               // Gap long enough: close the run one block past its data
               rec_end = data_end + 32'(BLOCK_BYTES);
               if (layout_mode == LAYOUT_MINIMIZED)
                  expect_record(run_base - record_end, rec_end - run_base, 1'b0);
               record_end = rec_end;
               run_active = 1'b0;
               zero_run   = 0;
            end else begin
               zero_run++;
            end
         end
         scan_offset = blk_end;
      end
      if (last) begin
         tail_len = (nbytes == BLOCK_BYTES) ? 0 : nbytes;
         tail     = (tail_len != 0) ? (data & ((64'h1 << (8 * tail_len)) - 64'h1)) : '0;
         if (layout_mode == LAYOUT_DELTA) begin
            // One record up to the last nonzero byte
            reach = data_end;
            if (tail != '0) begin
               i = tail_len;
               while (i > 0 && tail[8*(i-1) +: 8] == 8'h00)
                  i--;
               reach = scan_offset + 32'(i);
            end
            if (reach != '0)
               expect_record('0, reach, 1'b0);
         end else begin
            if (run_active) begin
               rec_end = (zero_run > 0) ? data_end + 32'(BLOCK_BYTES) : data_end;
               expect_record(run_base - record_end, rec_end - run_base, 1'b0);
               record_end = rec_end;
               run_active = 1'b0;
            end
            if (tail != '0)
               expect_record(scan_offset - record_end, 32'(tail_len), 1'b0);
         end
         expect_record('0, '0, 1'b1);
         clear_region();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] record mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got,
               want);
      mismatch_count++;
   endtask

   // Mostly no gap, some short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic int next_calm(input int calm);
      if (calm != 0)
         return calm - 1;
      return ($urandom_range(0, 99) < 3) ? $urandom_range(20, 80) : 0;
   endfunction

   function automatic logic [63:0] rand_block();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return '0;
      else if (r < 6)
         return 64'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7));
      return {$urandom, $urandom};
   endfunction

   task automatic add_block(input logic [63:0] data, input logic [3:0] vb, input logic last);
      block_item_type item;
      item.data        = data;
      item.valid_bytes = vb;
      item.last        = last;
      pending_blocks.push_back(item);
   endtask

   task automatic add_zero_blocks(input int count);
      repeat (count) add_block('0, 4'd8, 1'b0);
   endtask

   // Well-formed regions of random length with random content and tail size
   task automatic add_random_block();
      logic [63:0] data;
      logic [3:0]  vb;
      int          r;
      if (region_left == 0)
         region_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 24);
      data = rand_block();
      if (region_left == 1) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            vb = 4'd8;
         else if (r < 80)
            vb = 4'($urandom_range(1, 7));
         else if (r < 88)
            vb = 4'd0;
         else
            vb = 4'($urandom_range(9, 15));
         // Sometimes leave only junk above the valid bytes
         if (vb >= 1 && vb <= 7 && $urandom_range(0, 3) == 0)
            data = data & ~((64'h1 << (8 * vb)) - 64'h1);
         add_block(data, vb, 1'b1);
      end else begin
         add_block(data, 4'($urandom_range(0, 15)), 1'b0);
      end
      region_left--;
   endtask

   task automatic write_layout(input bit mode);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we      <= 1'b0;
      layout_mode = mode;
   endtask

   // Hold until every block is taken and every record has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_blocks.size() != 0 || req_tvalid || expected_records.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Block driver: predict on each transfer, then present the next block
   always @(posedge clock) begin : req_driver
      block_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
         req_calm   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            encode_block(req_tdata[DATA_W-1:0], req_tdata[DATA_W +: VB_W], req_tlast);
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_blocks.size() != 0) begin
               nxt = pending_blocks.pop_front();
               req_tdata  <= {{PAD_W{1'b0}}, nxt.valid_bytes, nxt.data};
               req_tlast  <= nxt.last;
               req_tvalid <= 1'b1;
               req_gap    <= (req_calm != 0) ? 0 : idle_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         req_calm <= next_calm(req_calm);
      end
   end

   // Record monitor: compare each transfer with the oldest expected record
   always @(posedge clock) begin : rsp_monitor
      enc_record_type got;
      enc_record_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
         rsp_calm   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.skip       = rsp_tdata[OFF_W-1:0];
            got.len        = rsp_tdata[2*OFF_W-1:OFF_W];
            got.end_marker = rsp_tlast;
            got.overflow   = rsp_tuser;
            if (expected_records.size() == 0) begin
               report_mismatch("unexpected record (skip)", got.skip, '0);
            end else begin
               want = expected_records.pop_front();
               if (got.skip !== want.skip)
                  report_mismatch("skip", got.skip, want.skip);
               if (got.len !== want.len)
                  report_mismatch("len", got.len, want.len);
               if (got.end_marker !== want.end_marker)
                  report_mismatch("end_marker", 32'(got.end_marker), 32'(want.end_marker));
               if (got.overflow !== want.overflow)
                  report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
            end
         end
         // Stall at random, with calm stretches of steady ready
         if (rsp_hold != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_hold - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_hold   <= (rsp_calm != 0) ? 0 : idle_len();
         end
         rsp_calm <= next_calm(rsp_calm);
      end
   end

   initial begin : stimulus
      int sent;
      int chunk;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      clear_region();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Minimized runs: extremes, junk above the tail, empty and oversized finals
      write_layout(LAYOUT_MINIMIZED);
      add_block(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
      add_block(64'h0000_0000_0000_0001, 4'd0, 1'b0);
      add_block('0, 4'd15, 1'b0);
      add_block('0, 4'd8, 1'b0);
      add_block(64'hFFFF_FFFF_FF00_0000, 4'd3, 1'b1);
      add_block('0, 4'd8, 1'b0);
      add_block(64'h8000_0000_0000_0000, 4'd8, 1'b0);
      add_block(64'h0000_0000_0000_0100, 4'd7, 1'b1);
      add_block(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
      add_block(64'h0000_0000_0000_FFFF, 4'd0, 1'b1);
      add_block('0, 4'd9, 1'b1);
      wait_idle();

      // Delta layout: all-zero region, byte-exact tail, block-aligned end
      write_layout(LAYOUT_DELTA);
      add_block('0, 4'd8, 1'b0);
      add_block('0, 4'd5, 1'b1);
      add_block(64'h0000_0000_0000_0001, 4'd8, 1'b0);
      add_block('0, 4'd8, 1'b0);
      add_block(64'hFF00_0000_0000_FF00, 4'd6, 1'b1);
      add_block(64'h0000_0000_0000_0001, 4'd8, 1'b0);
      add_block('0, 4'd8, 1'b1);
      // Switch layout in the middle of a region
      add_block(64'h0000_0000_0000_0005, 4'd8, 1'b0);
      add_block('0, 4'd8, 1'b0);
      wait_idle();
      write_layout(LAYOUT_MINIMIZED);
      add_block(64'h0000_0000_0000_0007, 4'd8, 1'b0);
      add_block(64'h0000_0000_0000_00AB, 4'd1, 1'b1);
      wait_idle();

      // Short gaps keep the run open, trailing zeros extend it by one block
      add_block(64'h0000_0000_0000_0011, 4'd8, 1'b0);
      add_zero_blocks(4);
      add_block(64'h0000_0000_0000_0022, 4'd8, 1'b0);
      add_zero_blocks(2);
      add_block('0, 4'd8, 1'b1);
      wait_idle();

      // Short gaps in delta layout, byte-exact tail end
      write_layout(LAYOUT_DELTA);
      add_block(64'h0000_0000_0000_0044, 4'd8, 1'b0);
      add_zero_blocks(5);
      add_block(64'h0000_0000_0000_0055, 4'd8, 1'b0);
      add_zero_blocks(3);
      add_block(64'h0000_0000_0066_0000, 4'd4, 1'b1);
      wait_idle();

      // Random phases; a phase may end in the middle of a region
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         write_layout(bit'($urandom_range(0, 1)));
         chunk = $urandom_range(8, 50);
         repeat (chunk) add_random_block();
         sent += chunk;
         wait_idle();
      end
      while (region_left != 0)
         add_random_block();
      wait_idle();

      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== sparse_zero_block_encoder_top.f =====
rtl/szbe_pkg.sv
rtl/szbe_front.sv
rtl/szbe_queue.sv
rtl/szbe_back.sv
rtl/sparse_zero_block_encoder_top.sv
sim/sparse_zero_block_encoder_top_tb.sv
